// File: sv/vfdd_pkg.sv
// ----------------------------------------------------------------------------
// vfdd_pkg
// Types, constants and lookup functions of the vertex format descriptor decoder.
// ----------------------------------------------------------------------------
package vfdd_pkg;

	localparam int LANE_COUNT_DEF  = 18;
	localparam int TYPED_LANES_DEF = 16;
	localparam int CODE_W          = 4;
	localparam int LANE_W          = 5;
	localparam int OFFS_W          = 9;

	localparam logic [3:0] USAGE_POSITION = 4'd0;
	localparam logic [3:0] USAGE_WEIGHT   = 4'd1;
	localparam logic [3:0] USAGE_INDICES  = 4'd2;
	localparam logic [3:0] USAGE_NORMAL   = 4'd3;
	localparam logic [3:0] USAGE_TEXCOORD = 4'd5;
	localparam logic [3:0] USAGE_TANGENT  = 4'd6;
	localparam logic [3:0] USAGE_BINORMAL = 4'd7;
	localparam logic [3:0] USAGE_COLOR    = 4'd10;

	localparam logic [1:0] NCLASS_NONE  = 2'd0;
	localparam logic [1:0] NCLASS_FLOAT = 2'd1;
	localparam logic [1:0] NCLASS_NORM  = 2'd2;
	localparam logic [1:0] NCLASS_INT   = 2'd3;

	localparam int ST_DECODED  = 0;
	localparam int ST_VALID    = 0;
	localparam int ST_UNKNOWN  = 1;
	localparam int ST_SIZE_MIS = 2;
	localparam int ST_CNT_MIS  = 3;

	typedef struct packed {
		logic [17:0] lane_mask;
		logic [63:0] type_codes;
		logic [15:0] declared_size;
		logic [7:0]  declared_count;
	} desc_item_t;

	typedef struct packed {
		logic              is_summary;
		logic [4:0]        lane_or_count;
		logic [3:0]        usage;
		logic [2:0]        usage_index;
		logic [3:0]        type_code;
		logic [3:0]        status_bits;
		logic [OFFS_W-1:0] offset_or_stride;
		logic [2:0]        component_count;
		logic [2:0]        component_bytes;
		logic [4:0]        element_bytes;
		logic [5:0]        format_number;
		logic [1:0]        number_class;
	} res_item_t;

	typedef struct packed {
		logic              bound;
		logic [CODE_W-1:0] code;
		logic [LANE_W-1:0] lane;
	} lane_slot_t;

	typedef struct packed {
		logic [2:0] comps;
		logic [2:0] comp_bytes;
		logic [4:0] total;
		logic [5:0] format;
		logic [1:0] nclass;
	} elem_t;

	typedef struct packed {
		logic clear;
		logic lane_go;
		logic sum_go;
	} emit_ctrl_t;

	// total of zero marks a code that does not decode
	function automatic elem_t elem_lookup(input logic [CODE_W-1:0] code);
		elem_t e;
		e = '0;
		case (code)
			4'd1:    e = '{3'd2, 3'd2, 5'd4,  6'd34, NCLASS_FLOAT};
			4'd3:    e = '{3'd4, 3'd2, 5'd8,  6'd11, NCLASS_FLOAT};
			4'd5:    e = '{3'd2, 3'd4, 5'd8,  6'd16, NCLASS_FLOAT};
			4'd6:    e = '{3'd3, 3'd4, 5'd12, 6'd6,  NCLASS_FLOAT};
			4'd7:    e = '{3'd4, 3'd4, 5'd16, 6'd2,  NCLASS_FLOAT};
			4'd8:    e = '{3'd4, 3'd1, 5'd4,  6'd30, NCLASS_INT};
			4'd9:    e = '{3'd4, 3'd1, 5'd4,  6'd28, NCLASS_NORM};
			4'd10:   e = '{3'd4, 3'd0, 5'd4,  6'd24, NCLASS_NORM};
			default: e = '0;
		endcase
		return e;
	endfunction

	function automatic logic [3:0] lane_usage(input logic [LANE_W-1:0] lane);
		logic [3:0] u;
		case (lane)
			5'd0:                       u = USAGE_POSITION;
			5'd1:                       u = USAGE_WEIGHT;
			5'd2:                       u = USAGE_INDICES;
			5'd3:                       u = USAGE_NORMAL;
			5'd4, 5'd5:                 u = USAGE_COLOR;
			5'd6, 5'd7, 5'd8, 5'd9,
			5'd10, 5'd11, 5'd12, 5'd13: u = USAGE_TEXCOORD;
			5'd14, 5'd15:               u = USAGE_TANGENT;
			5'd16, 5'd17:               u = USAGE_BINORMAL;
			default:                    u = USAGE_POSITION;
		endcase
		return u;
	endfunction

	function automatic logic [2:0] lane_usage_index(input logic [LANE_W-1:0] lane);
		logic [2:0] ix;
		case (lane)
			5'd5, 5'd7, 5'd15, 5'd17: ix = 3'd1;
			5'd8:                     ix = 3'd2;
			5'd9:                     ix = 3'd3;
			5'd10:                    ix = 3'd4;
			5'd11:                    ix = 3'd5;
			5'd12:                    ix = 3'd6;
			5'd13:                    ix = 3'd7;
			default:                  ix = 3'd0;
		endcase
		return ix;
	endfunction

endpackage

// File: sv/vfdd_cell.sv
// ----------------------------------------------------------------------------
// vfdd_cell
// One lane slot of the shift row: parallel load, shift from the upstream neighbor.
// ----------------------------------------------------------------------------
module vfdd_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic               shift,
	input  vfdd_pkg::lane_slot_t load_slot,
	input  vfdd_pkg::lane_slot_t next_slot,
	output vfdd_pkg::lane_slot_t slot
);
	import vfdd_pkg::*;

	lane_slot_t slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (load) begin
			slot_q <= load_slot;
		end else if (shift) begin
			slot_q <= next_slot;
		end
	end

	assign slot = slot_q;

endmodule

// File: sv/vfdd_emit.sv
// ----------------------------------------------------------------------------
// vfdd_emit
// Decodes the head lane, keeps offset, count and unknown flag, and holds the
// output item register.
// ----------------------------------------------------------------------------
module vfdd_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vfdd_pkg::emit_ctrl_t ctrl,
	input  vfdd_pkg::lane_slot_t head,
	input  logic [15:0]          declared_size,
	input  logic [7:0]           declared_count,
	input  logic                 res_ready,
	output logic                 res_valid,
	output vfdd_pkg::res_item_t  res,
	output logic                 out_free
);
	import vfdd_pkg::*;

	logic [OFFS_W-1:0] offset_q;
	logic [LANE_W-1:0] pop_q;
	logic              unknown_q;
	logic              valid_q;
	res_item_t         res_q;
	elem_t             e;
	logic              ok;
	logic              lane_wr;
	res_item_t         lane_res;
	res_item_t         sum_res;

	assign e       = elem_lookup(head.code);
	assign ok      = (e.total != '0);
	assign lane_wr = ctrl.lane_go && head.bound;
	assign out_free = !valid_q || res_ready;

	always_comb begin
		lane_res                   = '0;
		lane_res.lane_or_count     = head.lane;
		lane_res.usage             = lane_usage(head.lane);
		lane_res.usage_index       = lane_usage_index(head.lane);
		lane_res.type_code         = head.code;
		lane_res.status_bits[ST_DECODED] = ok;
		lane_res.offset_or_stride  = offset_q;
		if (ok) begin
			lane_res.component_count = e.comps;
			lane_res.component_bytes = e.comp_bytes;
			lane_res.element_bytes   = e.total;
			lane_res.format_number   = e.format;
			lane_res.number_class    = e.nclass;
		end

		sum_res                  = '0;
		sum_res.is_summary       = 1'b1;
		sum_res.lane_or_count    = pop_q;
		sum_res.offset_or_stride = offset_q;
		sum_res.status_bits[ST_VALID]    = (pop_q != '0) && !unknown_q;
		sum_res.status_bits[ST_UNKNOWN]  = unknown_q;
		sum_res.status_bits[ST_SIZE_MIS] = (declared_size != '0) && (offset_q != '0) &&
			(declared_size != {{(16-OFFS_W){1'b0}}, offset_q});
		sum_res.status_bits[ST_CNT_MIS]  = (declared_count != '0) &&
			(declared_count != {{(8-LANE_W){1'b0}}, pop_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q  <= '0;
			pop_q     <= '0;
			unknown_q <= 1'b0;
		end else if (ctrl.clear) begin
			offset_q  <= '0;
			pop_q     <= '0;
			unknown_q <= 1'b0;
		end else if (lane_wr) begin
			pop_q <= pop_q + 1'b1;
			if (ok) begin
				offset_q <= offset_q + {{(OFFS_W-5){1'b0}}, e.total};
			end else begin
				unknown_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (lane_wr || ctrl.sum_go) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lane_wr) begin
			res_q <= lane_res;
		end else if (ctrl.sum_go) begin
			res_q <= sum_res;
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;

endmodule

// File: sv/vertex_format_descriptor_decoder.sv
// ----------------------------------------------------------------------------
// vertex_format_descriptor_decoder
// Splits a vertex format descriptor into per-lane results and a summary.
// ----------------------------------------------------------------------------
// An accepted descriptor is loaded into a row of LANE_COUNT lane cells that
// shift one lane per cycle into the decode head: one step per lane, bound or
// not, plus one for the summary, which is always the last item of the run.
// Stalls on the result side hold the decoder only at bound lanes and the
// summary. A new descriptor is taken in the cycle its predecessor's summary
// enters the output register.
module vertex_format_descriptor_decoder #(
	parameter int LANE_COUNT  = vfdd_pkg::LANE_COUNT_DEF,
	parameter int TYPED_LANES = vfdd_pkg::TYPED_LANES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   desc_valid,
	output logic                   desc_ready,
	input  vfdd_pkg::desc_item_t   desc,
	output logic                   res_valid,
	input  logic                   res_ready,
	output vfdd_pkg::res_item_t    res
);
	import vfdd_pkg::*;

	localparam int STEP_W = $clog2(LANE_COUNT + 1);

	lane_slot_t        slots [LANE_COUNT];
	lane_slot_t        loads [LANE_COUNT];
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [15:0]       decl_size_q;
	logic [7:0]        decl_count_q;
	logic              accept;
	logic              step_sum;
	logic              step_lane;
	logic              adv;
	logic              out_free;
	emit_ctrl_t        ctrl;

	assign step_sum  = busy_q && (step_q == STEP_W'(LANE_COUNT));
	assign step_lane = busy_q && !step_sum;
	assign adv       = (step_lane && (!slots[0].bound || out_free)) || (step_sum && out_free);
	assign desc_ready = !busy_q || (step_sum && out_free);
	assign accept    = desc_valid && desc_ready;

	assign ctrl.clear   = accept;
	assign ctrl.lane_go = step_lane && adv;
	assign ctrl.sum_go  = step_sum && adv;

	genvar i;
	generate
		for (i = 0; i < LANE_COUNT; i++) begin : g_cell
			assign loads[i].bound = desc.lane_mask[i];
			assign loads[i].lane  = LANE_W'(i);
			if (i < TYPED_LANES) begin : g_typed
				assign loads[i].code = desc.type_codes[CODE_W*i +: CODE_W];
			end else begin : g_untyped
				assign loads[i].code = '0;
			end

			if (i == LANE_COUNT - 1) begin : g_tail
				vfdd_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.load      (accept),
					.shift     (ctrl.lane_go),
					.load_slot (loads[i]),
					.next_slot ('0),
					.slot      (slots[i])
				);
			end else begin : g_body
				vfdd_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.load      (accept),
					.shift     (ctrl.lane_go),
					.load_slot (loads[i]),
					.next_slot (slots[i+1]),
					.slot      (slots[i])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (adv) begin
			if (step_sum) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			decl_size_q  <= desc.declared_size;
			decl_count_q <= desc.declared_count;
		end
	end

	vfdd_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.head           (slots[0]),
		.declared_size  (decl_size_q),
		.declared_count (decl_count_q),
		.res_ready      (res_ready),
		.res_valid      (res_valid),
		.res            (res),
		.out_free       (out_free)
	);

endmodule

// File: tb/sv/tb_vertex_format_descriptor_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vertex_format_descriptor_decoder
// Self-checking testbench for the vertex format descriptor decoder.
// ----------------------------------------------------------------------------
// Descriptors go in through the desc handshake. Each accepted descriptor is
// decoded by a local model into its lane items and summary item, which queue
// up in order. Every item taken off the result side is compared field by field
// with the head of that queue. Directed cases cover the empty mask, every type
// code, the largest stride and the untyped lanes. Random descriptors follow,
// with and without idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_vertex_format_descriptor_decoder;
	import vfdd_pkg::*;

	localparam int LANES          = 18;
	localparam int TYPED          = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 2 * LANES + 4;

	localparam logic [3:0] TC_NONE     = 4'd0;
	localparam logic [3:0] TC_HALF2    = 4'd1;
	localparam logic [3:0] TC_HALF4    = 4'd3;
	localparam logic [3:0] TC_FLOAT2   = 4'd5;
	localparam logic [3:0] TC_FLOAT3   = 4'd6;
	localparam logic [3:0] TC_FLOAT4   = 4'd7;
	localparam logic [3:0] TC_UBYTE4   = 4'd8;
	localparam logic [3:0] TC_UBYTE4N  = 4'd9;
	localparam logic [3:0] TC_PACKED4N = 4'd10;

	typedef struct packed {
		logic [2:0] comps;
		logic [2:0] comp_bytes;
		logic [4:0] total;
		logic [5:0] format;
		logic [1:0] nclass;
	} elem_info_t;

	logic       clk;
	logic       arst_n;
	logic       desc_valid;
	logic       desc_ready;
	desc_item_t desc;
	logic       res_valid;
	logic       res_ready;
	res_item_t  res;

	res_item_t  pending_results[$];
	bit         throttle;
	int         error_count;
	int         descs_taken;
	int         results_checked;
	int         valid_descs;
	int         unknown_descs;
	int         quiet_cycles;

	vertex_format_descriptor_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc_ready (desc_ready),
		.desc       (desc),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic elem_info_t element_of(input logic [3:0] code);
		elem_info_t e;
		e = '0;
		case (code)
			TC_HALF2:    e = '{3'd2, 3'd2, 5'd4,  6'd34, NCLASS_FLOAT};
			TC_HALF4:    e = '{3'd4, 3'd2, 5'd8,  6'd11, NCLASS_FLOAT};
			TC_FLOAT2:   e = '{3'd2, 3'd4, 5'd8,  6'd16, NCLASS_FLOAT};
			TC_FLOAT3:   e = '{3'd3, 3'd4, 5'd12, 6'd6,  NCLASS_FLOAT};
			TC_FLOAT4:   e = '{3'd4, 3'd4, 5'd16, 6'd2,  NCLASS_FLOAT};
			TC_UBYTE4:   e = '{3'd4, 3'd1, 5'd4,  6'd30, NCLASS_INT};
			TC_UBYTE4N:  e = '{3'd4, 3'd1, 5'd4,  6'd28, NCLASS_NORM};
			TC_PACKED4N: e = '{3'd4, 3'd0, 5'd4,  6'd24, NCLASS_NORM};
			default:     e = '0;
		endcase
		return e;
	endfunction

	function automatic logic [3:0] usage_of(input int lane);
		if (lane == 0) return USAGE_POSITION;
		if (lane == 1) return USAGE_WEIGHT;
		if (lane == 2) return USAGE_INDICES;
		if (lane == 3) return USAGE_NORMAL;
		if (lane <= 5) return USAGE_COLOR;
		if (lane <= 13) return USAGE_TEXCOORD;
		if (lane <= 15) return USAGE_TANGENT;
		return USAGE_BINORMAL;
	endfunction

	function automatic logic [2:0] usage_index_of(input int lane);
		if (lane >= 4 && lane <= 5) return 3'(lane - 4);
		if (lane >= 6 && lane <= 13) return 3'(lane - 6);
		if (lane >= 14) return 3'(lane % 2);
		return 3'd0;
	endfunction

	// Returns the summary item; with record set, queues every item of the run.
	function automatic res_item_t decode_descriptor(input desc_item_t d, input bit record);
		res_item_t  r;
		elem_info_t e;
		logic [3:0] code;
		logic [8:0] offset;
		logic [4:0] bound;
		logic       unknown;
		logic       ok;
		offset  = '0;
		bound   = '0;
		unknown = 1'b0;
		for (int lane = 0; lane < LANES; lane++) begin
			if (d.lane_mask[lane]) begin
				bound = bound + 5'd1;
				code  = (lane < TYPED) ? d.type_codes[lane*4 +: 4] : TC_NONE;
				e     = element_of(code);
				ok    = (lane < TYPED) && (e.total != 0);
				r = '0;
				r.lane_or_count          = 5'(lane);
				r.usage                  = usage_of(lane);
				r.usage_index            = usage_index_of(lane);
				r.type_code              = code;
				r.status_bits[ST_DECODED] = ok;
				r.offset_or_stride       = offset;
				if (ok) begin
					r.component_count = e.comps;
					r.component_bytes = e.comp_bytes;
					r.element_bytes   = e.total;
					r.format_number   = e.format;
					r.number_class    = e.nclass;
					offset = offset + 9'(e.total);
				end else begin
					unknown = 1'b1;
				end
				if (record) pending_results.push_back(r);
			end
		end
		r = '0;
		r.is_summary                = 1'b1;
		r.lane_or_count             = bound;
		r.offset_or_stride          = offset;
		r.status_bits[ST_VALID]     = (bound != 0) && !unknown;
		r.status_bits[ST_UNKNOWN]   = unknown;
		r.status_bits[ST_SIZE_MIS]  = (d.declared_size != 0) && (offset != 0) &&
			(d.declared_size != 16'(offset));
		r.status_bits[ST_CNT_MIS]   = (d.declared_count != 0) &&
			(d.declared_count != 8'(bound));
		if (record) pending_results.push_back(r);
		return r;
	endfunction

	// Mostly decodable lanes with consistent declared sizes, plus noise.
	function automatic desc_item_t random_descriptor();
		desc_item_t d;
		res_item_t  s;
		int         pick;
		d.lane_mask = 18'($urandom);
		pick = $urandom_range(9);
		if (pick < 4) d.lane_mask[17:16] = 2'b00;
		else if (pick == 4) d.lane_mask = 18'(1) << $urandom_range(LANES - 1);
		else if (pick == 5) d.lane_mask = '1;
		if ($urandom_range(9) == 0) begin
			d.type_codes = {$urandom, $urandom};
		end else begin
			for (int lane = 0; lane < TYPED; lane++) begin
				case ($urandom_range(19))
					0:       d.type_codes[lane*4 +: 4] = TC_HALF2;
					1, 2:    d.type_codes[lane*4 +: 4] = TC_HALF4;
					3, 4:    d.type_codes[lane*4 +: 4] = TC_FLOAT2;
					5, 6:    d.type_codes[lane*4 +: 4] = TC_FLOAT3;
					7, 8:    d.type_codes[lane*4 +: 4] = TC_FLOAT4;
					9, 10:   d.type_codes[lane*4 +: 4] = TC_UBYTE4;
					11, 12:  d.type_codes[lane*4 +: 4] = TC_UBYTE4N;
					13, 14,
					15, 16:  d.type_codes[lane*4 +: 4] = TC_PACKED4N;
					default: d.type_codes[lane*4 +: 4] = 4'($urandom_range(15));
				endcase
			end
		end
		d.declared_size  = 16'($urandom);
		d.declared_count = 8'($urandom);
		s = decode_descriptor(d, 1'b0);
		pick = $urandom_range(9);
		if (pick < 3) d.declared_size = '0;
		else if (pick < 7) d.declared_size = 16'(s.offset_or_stride);
		pick = $urandom_range(9);
		if (pick < 3) d.declared_count = '0;
		else if (pick < 7) d.declared_count = 8'(s.lane_or_count);
		return d;
	endfunction

	task automatic send_desc(input desc_item_t d);
		@(negedge clk);
		while (throttle && ($urandom_range(99) < 18)) begin
			desc_valid <= 1'b0;
			@(negedge clk);
		end
		desc       <= d;
		desc_valid <= 1'b1;
		@(posedge clk);
		while (!desc_ready) @(posedge clk);
	endtask

	task automatic send_desc_fields(input logic [17:0] mask, input logic [63:0] codes,
			input logic [15:0] size, input logic [7:0] count);
		desc_item_t d;
		d.lane_mask      = mask;
		d.type_codes     = codes;
		d.declared_size  = size;
		d.declared_count = count;
		send_desc(d);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		desc_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// receiver
	always @(negedge clk)
		res_ready <= !(throttle && ($urandom_range(99) < 18));

	// result checker and descriptor monitor
	always @(posedge clk) begin
		res_item_t want;
		res_item_t summary;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with nothing pending: %h", res);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				check_field("is_summary", 32'(want.is_summary), 32'(res.is_summary));
				check_field("lane_or_count", 32'(want.lane_or_count),
					32'(res.lane_or_count));
				check_field("usage", 32'(want.usage), 32'(res.usage));
				check_field("usage_index", 32'(want.usage_index),
					32'(res.usage_index));
				check_field("type_code", 32'(want.type_code), 32'(res.type_code));
				check_field("status_bits", 32'(want.status_bits),
					32'(res.status_bits));
				check_field("offset_or_stride", 32'(want.offset_or_stride),
					32'(res.offset_or_stride));
				check_field("component_count", 32'(want.component_count),
					32'(res.component_count));
				check_field("component_bytes", 32'(want.component_bytes),
					32'(res.component_bytes));
				check_field("element_bytes", 32'(want.element_bytes),
					32'(res.element_bytes));
				check_field("format_number", 32'(want.format_number),
					32'(res.format_number));
				check_field("number_class", 32'(want.number_class),
					32'(res.number_class));
			end
		end
		if (arst_n && desc_valid && desc_ready) begin
			summary = decode_descriptor(desc, 1'b1);
			descs_taken++;
			if (summary.status_bits[ST_VALID]) valid_descs++;
			if (summary.status_bits[ST_UNKNOWN]) unknown_descs++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((desc_valid && desc_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", quiet_cycles);
			$display("vertex_format_descriptor_decoder: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic test_empty_mask();
		send_desc_fields('0, 64'h0123_4567_89AB_CDEF, 16'hFFFF, 8'hFF);
		send_desc_fields('0, '0, '0, '0);
	endtask

	task automatic test_every_code();
		send_desc_fields('1, 64'hFEDC_BA98_7654_3210, 16'd0, 8'd18);
		send_desc_fields(18'h0FFFF, 64'h0123_4567_89AB_CDEF, 16'd88, 8'd16);
		send_desc_fields(18'h0FFFF, '1, 16'd1, 8'd1);
		send_desc_fields(18'h0FFFF, '0, 16'd0, 8'd0);
		send_desc_fields(18'h000FF, 64'h0000_0000_A987_6531, 16'd64, 8'd8);
	endtask

	task automatic test_stride_limits();
		send_desc_fields(18'h0FFFF, 64'h7777_7777_7777_7777, 16'd256, 8'd16);
		send_desc_fields(18'h0FFFF, 64'h7777_7777_7777_7777, 16'hFFFF, 8'hFF);
		send_desc_fields(18'h0FFFF, 64'h7777_7777_7777_7777, 16'd0, 8'd0);
		send_desc_fields(18'h00001, 64'h0000_0000_0000_000A, 16'd4, 8'd1);
		send_desc_fields(18'h08000, 64'h1000_0000_0000_0000, 16'd3, 8'd2);
	endtask

	task automatic test_untyped_lanes();
		send_desc_fields(18'h10000, '1, 16'd5, 8'd1);
		send_desc_fields(18'h20000, 64'h7777_7777_7777_7777, 16'd0, 8'd3);
		send_desc_fields(18'h30003, 64'h0000_0000_0000_0057, 16'd24, 8'd4);
	endtask

	task automatic test_random_throttled(input int count);
		throttle = 1'b1;
		repeat (count) send_desc(random_descriptor());
	endtask

	task automatic test_random_burst(input int count);
		throttle = 1'b0;
		repeat (count) send_desc(random_descriptor());
		throttle = 1'b1;
	endtask

	task automatic test_drain_pause(input int count);
		throttle = 1'b1;
		repeat (count) send_desc(random_descriptor());
		wait_drained();
		repeat (count) send_desc(random_descriptor());
	endtask

	initial begin
		arst_n          = 1'b0;
		desc_valid      = 1'b0;
		desc            = '0;
		res_ready       = 1'b0;
		throttle        = 1'b1;
		error_count     = 0;
		descs_taken     = 0;
		results_checked = 0;
		valid_descs     = 0;
		unknown_descs   = 0;
		quiet_cycles    = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_empty_mask();
		test_every_code();
		test_stride_limits();
		test_untyped_lanes();
		test_random_throttled(100);
		test_random_burst(60);
		test_drain_pause(20);
		test_random_throttled(50);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d result items never arrived", pending_results.size());
			error_count++;
		end
		$display("run covered %0d descriptors and %0d result items", descs_taken,
			results_checked);
		$display("%0d descriptors fully decoded, %0d with undecodable lanes",
			valid_descs, unknown_descs);
		if (error_count == 0) begin
			$display("vertex_format_descriptor_decoder: match");
		end else begin
			$display("vertex_format_descriptor_decoder: mismatch");
		end
		$finish;
	end

endmodule

// File: vertex_format_descriptor_decoder.f
sv/vfdd_pkg.sv
sv/vfdd_cell.sv
sv/vfdd_emit.sv
sv/vertex_format_descriptor_decoder.sv
tb/sv/tb_vertex_format_descriptor_decoder.sv
